>>> hw/rtl/nearest_point_distance_binner_defines.svh
// assertion macros for the nearest point distance binner
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef NEAREST_POINT_DISTANCE_BINNER_DEFINES_SVH
`define NEAREST_POINT_DISTANCE_BINNER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every edge outside reset
`define NPDB_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("npdb assertion failed");

// condition that must hold in the cycle after a trigger
`define NPDB_ASSERT_NEXT(label, trig, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error("npdb assertion failed");

`else

`define NPDB_ASSERT(label, prop)
`define NPDB_ASSERT_NEXT(label, trig, prop)

`endif

`endif

>>> hw/rtl/npdb_pkg.sv
// shared types and constants of the nearest point distance binner
// used by npdb_search and nearest_point_distance_binner; no dependencies
package npdb_pkg;

   localparam int COORD_W  = 24;
   localparam int CODE_W   = 20;
   localparam int LIMIT_W  = 16;
   localparam int PT_W     = 2 * COORD_W;
   localparam int SQ_W     = 2 * COORD_W;
   localparam int DIST_W   = SQ_W + 1;
   localparam int LIM_SQ_W = 2 * LIMIT_W;
   localparam int CNT_W    = 32;
   localparam int STORED_W = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [CODE_W-1:0]  WANTED_CODE_RST = '0;
   localparam logic [LIMIT_W-1:0] LIMIT_NEAR_RST  = 16'd1000;
   localparam logic [LIMIT_W-1:0] LIMIT_MID_RST   = 16'd2000;
   localparam logic [LIMIT_W-1:0] LIMIT_FAR_RST   = 16'd5000;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_QUERY = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      STAT_QUERY_DONE = 3'd0,
      STAT_STORED     = 3'd1,
      STAT_SKIPPED    = 3'd2,
      STAT_DROPPED    = 3'd3,
      STAT_CLEARED    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_WANTED_CODE = 2'd0,
      CSR_LIMIT_NEAR  = 2'd1,
      CSR_LIMIT_MID   = 2'd2,
      CSR_LIMIT_FAR   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_CLASSIFY,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic start;   // new query: clear best
      logic issue;   // table read issued this cycle
   } scan_ctl_type;

   typedef struct packed {
      logic active;  // an entry is still in flight
   } scan_sts_type;

endpackage

>>> hw/rtl/npdb_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module npdb_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/npdb_search.sv
// distance pipeline: abs difference, square, sum, running minimum
// depends on npdb_pkg and the assertion macro header
`include "nearest_point_distance_binner_defines.svh"

module npdb_search
   import npdb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  scan_ctl_type        ctl,
   input  logic [PT_W-1:0]     rd_data,
   input  logic [COORD_W-1:0]  query_x,
   input  logic [COORD_W-1:0]  query_y,
   output scan_sts_type        sts,
   output logic [DIST_W-1:0]   best
);

   logic                vld_rd_ff, vld_dif_ff, vld_sq_ff, vld_sum_ff;
   logic [COORD_W-1:0]  dx_ff, dy_ff, dx_in, dy_in;
   logic [SQ_W-1:0]     sqx_ff, sqy_ff;
   logic [DIST_W-1:0]   sum_ff;
   logic [DIST_W-1:0]   best_ff;
   logic                have_ff;
   logic [COORD_W-1:0]  px, py;

   assign px = rd_data[PT_W-1:COORD_W];
   assign py = rd_data[COORD_W-1:0];

   always_comb begin
      dx_in = (px >= query_x) ? (px - query_x) : (query_x - px);
      dy_in = (py >= query_y) ? (py - query_y) : (query_y - py);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_rd_ff  <= 1'b0;
         vld_dif_ff <= 1'b0;
         vld_sq_ff  <= 1'b0;
         vld_sum_ff <= 1'b0;
         have_ff    <= 1'b0;
      end else begin
         vld_rd_ff  <= ctl.issue;
         vld_dif_ff <= vld_rd_ff;
         vld_sq_ff  <= vld_dif_ff;
         vld_sum_ff <= vld_sq_ff;
         if (ctl.start) begin
            have_ff <= 1'b0;
         end else if (vld_sum_ff) begin
            have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      sqx_ff <= {{COORD_W{1'b0}}, dx_ff} * {{COORD_W{1'b0}}, dx_ff};
      sqy_ff <= {{COORD_W{1'b0}}, dy_ff} * {{COORD_W{1'b0}}, dy_ff};
      sum_ff <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
      if (ctl.start) begin
         best_ff <= '0;
      end else if (vld_sum_ff && (!have_ff || sum_ff < best_ff)) begin
         best_ff <= sum_ff;
      end
   end

   assign sts.active = vld_rd_ff | vld_dif_ff | vld_sq_ff | vld_sum_ff;
   assign best       = best_ff;

   // once a first distance is taken the minimum can only shrink
   `NPDB_ASSERT_NEXT(a_best_monotone, have_ff && !ctl.start, best_ff <= $past(best_ff))

endmodule

>>> hw/rtl/nearest_point_distance_binner.sv
// top level of the nearest point distance binner: control, registers, counters
// depends on npdb_pkg, npdb_ram, npdb_search and the assertion macro header
`include "nearest_point_distance_binner_defines.svh"

// Load, clear and the unused mode keep busy low, and the result strobe
// comes in the cycle after start. A query reads the point table once per
// stored point through the single read port of the table ram, then a four
// stage distance pipeline drains, the bin is picked and the counter updated:
// busy is high through the scan, drain, classify and finish states, and the
// result strobe is registered from the finish state, which an empty table
// enters straight from idle. rsp_valid is high for one cycle per item and cannot
// be held off; the counters and points_stored ports show live state and are
// the item's values during that cycle. The table needs no clearing pass.
module nearest_point_distance_binner
   import npdb_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_mode,
   input  logic [CODE_W-1:0]      req_point_code,
   input  logic [COORD_W-1:0]     req_coord_x,
   input  logic [COORD_W-1:0]     req_coord_y,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_status,
   output logic [1:0]             rsp_bin_index,
   output logic [DIST_W-1:0]      rsp_nearest_sq_distance,
   output logic                   rsp_table_empty,
   output logic [CNT_W-1:0]       rsp_count_bin0,
   output logic [CNT_W-1:0]       rsp_count_bin1,
   output logic [CNT_W-1:0]       rsp_count_bin2,
   output logic [CNT_W-1:0]       rsp_count_bin3,
   output logic [STORED_W-1:0]    rsp_points_stored,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int FW = $clog2(MAX_POINTS + 1);

   state_type             state_ff, state_in;
   logic [FW-1:0]         fill_ff, fill_in;
   logic [FW-1:0]         scan_cnt_ff, scan_cnt_in;
   logic [COORD_W-1:0]    qx_ff, qy_ff;
   logic                  q_load;
   logic [LIM_SQ_W-1:0]   lim_sq_ff [3];
   logic [1:0]            bin_ff, bin_in;
   logic                  empty_ff, empty_in;
   logic [CNT_W-1:0]      cnt_ff [4];
   logic                  cnt_clr, cnt_inc;

   logic [CODE_W-1:0]     wanted_ff;
   logic [LIMIT_W-1:0]    lim_near_ff, lim_mid_ff, lim_far_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [1:0]            rsp_bin_ff, rsp_bin_in;
   logic [DIST_W-1:0]     rsp_dist_ff, rsp_dist_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   logic                  accept;
   logic                  ram_wr_en;
   logic [PT_W-1:0]       ram_rd_data;
   scan_ctl_type          scan_ctl;
   scan_sts_type          scan_sts;
   logic [DIST_W-1:0]     best;
   logic [FW+STORED_W-1:0] fill_ext;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_ff   <= WANTED_CODE_RST;
         lim_near_ff <= LIMIT_NEAR_RST;
         lim_mid_ff  <= LIMIT_MID_RST;
         lim_far_ff  <= LIMIT_FAR_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_WANTED_CODE: wanted_ff   <= csr_data[CODE_W-1:0];
            CSR_LIMIT_NEAR:  lim_near_ff <= csr_data[LIMIT_W-1:0];
            CSR_LIMIT_MID:   lim_mid_ff  <= csr_data[LIMIT_W-1:0];
            CSR_LIMIT_FAR:   lim_far_ff  <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      scan_cnt_in   = scan_cnt_ff;
      bin_in        = bin_ff;
      empty_in      = empty_ff;
      q_load        = 1'b0;
      cnt_clr       = 1'b0;
      cnt_inc       = 1'b0;
      ram_wr_en     = 1'b0;
      scan_ctl      = '0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STAT_SKIPPED;
      rsp_bin_in    = '0;
      rsp_dist_in   = '0;
      rsp_empty_in  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               unique case (req_mode)
                  MODE_LOAD: begin
                     if (req_point_code != wanted_ff) begin
                        rsp_status_in = STAT_SKIPPED;
                     end else if (fill_ff >= FW'(MAX_POINTS)) begin
                        rsp_status_in = STAT_DROPPED;
                     end else begin
                        ram_wr_en     = 1'b1;
                        fill_in       = fill_ff + 1'b1;
                        rsp_status_in = STAT_STORED;
                     end
                  end
                  MODE_QUERY: begin
                     rsp_valid_in   = 1'b0;
                     q_load         = 1'b1;
                     scan_ctl.start = 1'b1;
                     scan_cnt_in    = '0;
                     bin_in         = '0;
                     if (fill_ff == '0) begin
                        empty_in = 1'b1;
                        state_in = S_FINISH;
                     end else begin
                        empty_in = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  MODE_CLEAR: begin
                     fill_in       = '0;
                     cnt_clr       = 1'b1;
                     rsp_status_in = STAT_CLEARED;
                  end
                  default: begin
                     rsp_status_in = STAT_SKIPPED;
                  end
               endcase
            end
         end
         S_SCAN: begin
            scan_ctl.issue = 1'b1;
            scan_cnt_in    = scan_cnt_ff + 1'b1;
            if (scan_cnt_in == fill_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!scan_sts.active) begin
               state_in = S_CLASSIFY;
            end
         end
         S_CLASSIFY: begin
            // inclusive bounds tested in order near, mid, far
            priority if (best <= DIST_W'(lim_sq_ff[0])) begin
               bin_in = 2'd0;
            end else if (best <= DIST_W'(lim_sq_ff[1])) begin
               bin_in = 2'd1;
            end else if (best <= DIST_W'(lim_sq_ff[2])) begin
               bin_in = 2'd2;
            end else begin
               bin_in = 2'd3;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cnt_inc       = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_QUERY_DONE;
            rsp_bin_in    = bin_ff;
            rsp_dist_in   = best;
            rsp_empty_in  = empty_ff;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_cnt_ff   <= scan_cnt_in;
      bin_ff        <= bin_in;
      empty_ff      <= empty_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bin_ff    <= rsp_bin_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_empty_ff  <= rsp_empty_in;
      if (q_load) begin
         qx_ff        <= req_coord_x;
         qy_ff        <= req_coord_y;
         lim_sq_ff[0] <= {{LIMIT_W{1'b0}}, lim_near_ff} * {{LIMIT_W{1'b0}}, lim_near_ff};
         lim_sq_ff[1] <= {{LIMIT_W{1'b0}}, lim_mid_ff} * {{LIMIT_W{1'b0}}, lim_mid_ff};
         lim_sq_ff[2] <= {{LIMIT_W{1'b0}}, lim_far_ff} * {{LIMIT_W{1'b0}}, lim_far_ff};
      end
   end

   // saturating bin counters
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (reset || cnt_clr) begin
            cnt_ff[i] <= '0;
         end else if (cnt_inc && (bin_ff == 2'(i)) && (cnt_ff[i] != '1)) begin
            cnt_ff[i] <= cnt_ff[i] + 1'b1;
         end
      end
   end

   npdb_ram #(
      .WIDTH (PT_W),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data ({req_coord_x, req_coord_y}),
      .rd_en   (scan_ctl.issue),
      .rd_addr (scan_cnt_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   npdb_search u_search (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .rd_data (ram_rd_data),
      .query_x (qx_ff),
      .query_y (qy_ff),
      .sts     (scan_sts),
      .best    (best)
   );

   assign fill_ext = {{STORED_W{1'b0}}, fill_ff};

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = rsp_status_ff;
   assign rsp_bin_index           = rsp_bin_ff;
   assign rsp_nearest_sq_distance = rsp_dist_ff;
   assign rsp_table_empty         = rsp_empty_ff;
   assign rsp_count_bin0          = cnt_ff[0];
   assign rsp_count_bin1          = cnt_ff[1];
   assign rsp_count_bin2          = cnt_ff[2];
   assign rsp_count_bin3          = cnt_ff[3];
   assign rsp_points_stored       = fill_ext[STORED_W-1:0];

   `NPDB_ASSERT(a_fill_bound, fill_ff <= FW'(MAX_POINTS))
   `NPDB_ASSERT(a_write_idle, ram_wr_en |-> (state_ff == S_IDLE))
   `NPDB_ASSERT_NEXT(a_finish_strobe, state_ff == S_FINISH, rsp_valid && !busy)

endmodule

>>> verif/tb_nearest_point_distance_binner.sv
// self-checking testbench for nearest_point_distance_binner
// depends on npdb_pkg and the rtl of the block; stimulus and prediction live here
`timescale 1ns / 100ps

module tb_nearest_point_distance_binner;
   import npdb_pkg::*;

   localparam int SITE_CAPACITY = 1024;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [COORD_W-1:0] COORD_MAX = '1;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [2:0]                 status;
      logic [1:0]                 bin_index;
      logic [DIST_W-1:0]          sq_dist;
      logic                       empty;
      logic [3:0][CNT_W-1:0]      counts;
      logic [STORED_W-1:0]        stored;
   } bin_outcome_type;

   // mirrors the table, registers and bin counters; predicts each outcome
   class distance_bin_tracker;
      logic [CODE_W-1:0]  wanted_code;
      logic [LIMIT_W-1:0] limit_near;
      logic [LIMIT_W-1:0] limit_mid;
      logic [LIMIT_W-1:0] limit_far;
      logic [COORD_W-1:0] site_x [SITE_CAPACITY];
      logic [COORD_W-1:0] site_y [SITE_CAPACITY];
      int unsigned        fill;
      logic [CNT_W-1:0]   bin_count [4];
      bin_outcome_type    awaited [$];
      int unsigned        failures;

      function new();
         wanted_code = WANTED_CODE_RST;
         limit_near  = LIMIT_NEAR_RST;
         limit_mid   = LIMIT_MID_RST;
         limit_far   = LIMIT_FAR_RST;
         fill        = 0;
         foreach (bin_count[i]) bin_count[i] = '0;
         failures    = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_WANTED_CODE: wanted_code = data;
            CSR_LIMIT_NEAR:  limit_near  = data[LIMIT_W-1:0];
            CSR_LIMIT_MID:   limit_mid   = data[LIMIT_W-1:0];
            CSR_LIMIT_FAR:   limit_far   = data[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [DIST_W-1:0] squared(logic [DIST_W-1:0] v);
         return v * v;
      endfunction

      function void note_request(logic [1:0] mode, logic [CODE_W-1:0] code,
                                 logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
         bin_outcome_type   r;
         logic [DIST_W-1:0] best;
         logic [DIST_W-1:0] d;
         logic [DIST_W-1:0] dx;
         logic [DIST_W-1:0] dy;
         int                bin_sel;
         r = '0;
         case (mode)
            MODE_LOAD: begin
               if (code != wanted_code)
                  r.status = STAT_SKIPPED;
               else if (fill >= SITE_CAPACITY)
                  r.status = STAT_DROPPED;
               else begin
                  site_x[fill] = x;
                  site_y[fill] = y;
                  fill++;
                  r.status = STAT_STORED;
               end
            end
            MODE_QUERY: begin
               r.status = STAT_QUERY_DONE;
               bin_sel = 0;
               if (fill == 0) begin
                  // empty table lands in the nearest bin
                  r.empty = 1'b1;
               end else begin
                  best = '0;
                  for (int i = 0; i < fill; i++) begin
                     dx = (site_x[i] >= x) ? site_x[i] - x : x - site_x[i];
                     dy = (site_y[i] >= y) ? site_y[i] - y : y - site_y[i];
                     d = squared(dx) + squared(dy);
                     if (i == 0 || d < best)
                        best = d;
                  end
                  r.sq_dist = best;
                  // bounds are inclusive and tested in order, even when out of order
                  if (best <= squared(limit_near))
                     bin_sel = 0;
                  else if (best <= squared(limit_mid))
                     bin_sel = 1;
                  else if (best <= squared(limit_far))
                     bin_sel = 2;
                  else
                     bin_sel = 3;
               end
               r.bin_index = bin_sel[1:0];
               if (bin_count[bin_sel] != '1)
                  bin_count[bin_sel]++;
            end
            MODE_CLEAR: begin
               fill = 0;
               foreach (bin_count[i]) bin_count[i] = '0;
               r.status = STAT_CLEARED;
            end
            default: r.status = STAT_SKIPPED;
         endcase
         r.counts = {bin_count[3], bin_count[2], bin_count[1], bin_count[0]};
         r.stored = fill[STORED_W-1:0];
         awaited = {awaited, r};
      endfunction

      function string describe(bin_outcome_type r);
         return $sformatf("status %0d bin %0d dist %0d empty %0d counts %0d %0d %0d %0d stored %0d",
                          r.status, r.bin_index, r.sq_dist, r.empty, r.counts[0], r.counts[1],
                          r.counts[2], r.counts[3], r.stored);
      endfunction

      function void check_response(bin_outcome_type got);
         bin_outcome_type want;
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected result: %s", describe(got));
            return;
         end
         want = awaited.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("result mismatch at %0t", $realtime);
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(got));
            end
         end
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_mode = MODE_LOAD;
   logic [CODE_W-1:0]     req_point_code = '0;
   logic [COORD_W-1:0]    req_coord_x = '0;
   logic [COORD_W-1:0]    req_coord_y = '0;
   logic                  rsp_valid;
   logic [2:0]            rsp_status;
   logic [1:0]            rsp_bin_index;
   logic [DIST_W-1:0]     rsp_nearest_sq_distance;
   logic                  rsp_table_empty;
   logic [CNT_W-1:0]      rsp_count_bin0;
   logic [CNT_W-1:0]      rsp_count_bin1;
   logic [CNT_W-1:0]      rsp_count_bin2;
   logic [CNT_W-1:0]      rsp_count_bin3;
   logic [STORED_W-1:0]   rsp_points_stored;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   distance_bin_tracker tracker = new();

   nearest_point_distance_binner #(
      .MAX_POINTS(SITE_CAPACITY)
   ) dut (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_mode                (req_mode),
      .req_point_code          (req_point_code),
      .req_coord_x             (req_coord_x),
      .req_coord_y             (req_coord_y),
      .rsp_valid               (rsp_valid),
      .rsp_status              (rsp_status),
      .rsp_bin_index           (rsp_bin_index),
      .rsp_nearest_sq_distance (rsp_nearest_sq_distance),
      .rsp_table_empty         (rsp_table_empty),
      .rsp_count_bin0          (rsp_count_bin0),
      .rsp_count_bin1          (rsp_count_bin1),
      .rsp_count_bin2          (rsp_count_bin2),
      .rsp_count_bin3          (rsp_count_bin3),
      .rsp_points_stored       (rsp_points_stored),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         tracker.check_response({rsp_status, rsp_bin_index, rsp_nearest_sq_distance,
                                 rsp_table_empty, rsp_count_bin3, rsp_count_bin2,
                                 rsp_count_bin1, rsp_count_bin0, rsp_points_stored});
   end

   // start stays high after a transfer; the next call either replaces the item or idles
   task automatic send_item(logic [1:0] mode, logic [CODE_W-1:0] code,
                            logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      @(negedge clock);
      start          = 1'b1;
      req_mode       = mode;
      req_point_code = code;
      req_coord_x    = x;
      req_coord_y    = y;
      @(posedge clock);
      while (busy) @(posedge clock);
      tracker.note_request(mode, code, x, y);
   endtask

   task automatic pause_sender(int unsigned cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      start = 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   task automatic program_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_register(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // upper data bits are don't-care for the limit registers
   task automatic program_limits(logic [LIMIT_W-1:0] near_m, logic [LIMIT_W-1:0] mid_m,
                                 logic [LIMIT_W-1:0] far_m);
      program_register(CSR_LIMIT_NEAR, {4'($urandom), near_m});
      program_register(CSR_LIMIT_MID,  {4'($urandom), mid_m});
      program_register(CSR_LIMIT_FAR,  {4'($urandom), far_m});
   endtask

   function automatic int unsigned pick_spread();
      case ($urandom_range(0, 9))
         0:       return 0;
         1, 2:    return 1500;
         3, 4:    return 4000;
         5, 6:    return 8000;
         7, 8:    return 80000;
         default: return 1 << COORD_W;
      endcase
   endfunction

   // clamping keeps the edges of the coordinate range well visited
   function automatic logic [COORD_W-1:0] near_coord(int unsigned center, int unsigned spread);
      longint v;
      v = longint'(center) + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
      if (v < 0)
         v = 0;
      if (v > longint'(COORD_MAX))
         v = longint'(COORD_MAX);
      return v[COORD_W-1:0];
   endfunction

   task automatic random_item(int unsigned center, int unsigned gap_pct);
      logic [1:0]        mode;
      logic [CODE_W-1:0] code;
      int unsigned       roll;
      int unsigned       spread;
      if ($urandom_range(0, 99) < gap_pct)
         pause_sender($urandom_range(1, 6));
      if ($urandom_range(0, 99) < 2)
         wait_for_results();
      roll = $urandom_range(0, 99);
      // keep tables short so queries stay cheap
      if (tracker.fill > 40)
         mode = MODE_CLEAR;
      else if (roll < 2)
         mode = MODE_UNUSED;
      else if (roll < 5)
         mode = MODE_CLEAR;
      else if (roll < 55)
         mode = MODE_LOAD;
      else
         mode = MODE_QUERY;
      code = ($urandom_range(0, 99) < 85) ? tracker.wanted_code : CODE_W'($urandom);
      spread = pick_spread();
      send_item(mode, code, near_coord(center, spread), near_coord(center, spread));
   endtask

   initial begin
      int unsigned       center;
      int unsigned       gap_pct;
      logic [LIMIT_W-1:0] lim_a;
      logic [LIMIT_W-1:0] lim_b;
      logic [CODE_W-1:0] fill_code;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part with the register values from reset
      send_item(MODE_QUERY, '0, 24'd5, 24'd5);
      send_item(MODE_LOAD, 20'd1, 24'd10, 24'd10);
      send_item(MODE_UNUSED, '0, 24'd10, 24'd10);
      send_item(MODE_LOAD, '0, '0, '0);
      send_item(MODE_LOAD, '0, COORD_MAX, COORD_MAX);
      send_item(MODE_QUERY, '1, '0, '0);
      send_item(MODE_QUERY, '0, COORD_MAX, '0);
      send_item(MODE_QUERY, '0, 24'h800000, 24'h7FFFFF);
      send_item(MODE_CLEAR, '0, '0, '0);
      send_item(MODE_QUERY, '0, 24'd1000000, 24'd1000000);
      send_item(MODE_LOAD, '0, 24'd1000000, 24'd1000000);
      // distances on and just past each inclusive bound
      send_item(MODE_QUERY, '0, 24'd1001000, 24'd1000000);
      send_item(MODE_QUERY, '0, 24'd1001001, 24'd1000000);
      send_item(MODE_QUERY, '0, 24'd1002000, 24'd1000000);
      send_item(MODE_QUERY, '0, 24'd1002001, 24'd1000000);
      send_item(MODE_QUERY, '0, 24'd1000000, 24'd1005000);
      send_item(MODE_QUERY, '0, 24'd1000000, 24'd1005001);
      send_item(MODE_QUERY, '0, 24'd999000, 24'd1000000);
      send_item(MODE_LOAD, '0, 24'd1000000, 24'd1000003);
      send_item(MODE_QUERY, '0, 24'd1000000, 24'd1000002);
      send_item(MODE_CLEAR, '0, '0, '0);

      for (int phase = 0; phase < 6; phase++) begin
         wait_for_results();
         center = $urandom_range(0, COORD_MAX);
         case (phase)
            0: begin
               program_register(CSR_WANTED_CODE, CODE_W'($urandom));
               program_limits(16'd1000, 16'd2000, 16'd5000);
            end
            1: begin
               program_register(CSR_WANTED_CODE, CODE_W'($urandom));
               lim_a = LIMIT_W'($urandom_range(0, 3000));
               lim_b = lim_a + LIMIT_W'($urandom_range(0, 5000));
               program_limits(lim_a, lim_b, lim_b + LIMIT_W'($urandom_range(0, 20000)));
            end
            2: begin
               program_register(CSR_WANTED_CODE, '1);
               program_limits('0, '0, '0);
               center = 0;
            end
            3: begin
               program_register(CSR_WANTED_CODE, '0);
               program_limits('1, '1, '1);
               center = COORD_MAX;
            end
            4: program_limits(16'd4000, 16'd500, 16'd2500);
            default: begin
               program_register(CSR_WANTED_CODE, CODE_W'($urandom));
               program_limits(LIMIT_W'($urandom), LIMIT_W'($urandom), LIMIT_W'($urandom));
            end
         endcase
         gap_pct = (phase < 2) ? 29 : (phase < 4) ? 54 : 0;
         repeat (97) random_item(center, gap_pct);
      end

      // fill the table to capacity, then overflow it
      wait_for_results();
      fill_code = CODE_W'($urandom);
      program_register(CSR_WANTED_CODE, fill_code);
      center = $urandom_range(0, COORD_MAX);
      send_item(MODE_CLEAR, '0, '0, '0);
      repeat (SITE_CAPACITY)
         send_item(MODE_LOAD, fill_code, near_coord(center, 80000), near_coord(center, 80000));
      send_item(MODE_LOAD, fill_code, near_coord(center, 4000), near_coord(center, 4000));
      send_item(MODE_LOAD, fill_code, '0, COORD_MAX);
      send_item(MODE_LOAD, fill_code ^ 20'd1, '0, '0);
      send_item(MODE_QUERY, '0, near_coord(center, 4000), near_coord(center, 4000));
      send_item(MODE_QUERY, '0, COORD_MAX, '0);
      send_item(MODE_CLEAR, '0, '0, '0);
      send_item(MODE_QUERY, '0, near_coord(center, 4000), near_coord(center, 4000));

      wait_for_results();
      repeat (40) @(posedge clock);
      if (tracker.failures == 0 && tracker.outstanding() == 0)
         $display("nearest_point_distance_binner regression: pass");
      else
         $display("nearest_point_distance_binner regression: fail");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("nearest_point_distance_binner regression: fail");
      $finish;
   end

endmodule
